[sv/assert_macros.svh]
// Assertion macros used by the top level of the split point finder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SSPF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sspf assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SSPF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sspf assertion failed");

`endif

[sv/sspf_pkg.sv]
// Types, constants and the fractional power table of the split point finder.
package sspf_pkg;

    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [47:0] SCORE_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } sspf_op_t;

    typedef struct packed {
        logic     start;
        sspf_op_t op;
    } sspf_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sspf_stat_t;

    // floored square root, elaboration use only
    function automatic logic [31:0] isqrt_c(input logic [63:0] v);
        logic [65:0] rem;
        logic [65:0] a;
        logic [65:0] tr;
        logic [31:0] root;
        logic [63:0] x;
        rem  = '0;
        root = '0;
        x    = v;
        for (int i = 0; i < 32; i++) begin
            a  = {rem[63:0], x[63:62]};
            x  = {x[61:0], 2'b00};
            tr = {32'd0, root, 2'b01};
            if (a >= tr) begin
                rem  = a - tr;
                root = {root[30:0], 1'b1};
            end else begin
                rem  = a;
                root = {root[30:0], 1'b0};
            end
        end
        return root;
    endfunction

    // 2^-(2^-(j+1)) in Q0.32, by repeated square roots
    function automatic logic [15:0][31:0] build_k();
        logic [15:0][31:0] t;
        logic [31:0]       k;
        k = isqrt_c(64'h8000_0000_0000_0000);
        for (int j = 0; j < 16; j++) begin
            t[j] = k;
            k    = isqrt_c({k, 32'd0});
        end
        return t;
    endfunction

    localparam logic [15:0][31:0] K_TAB = build_k();

endpackage

[sv/sspf_mul.sv]
// Shared 32x32 multiplier with a registered product.
module sspf_mul
    import sspf_pkg::*;
(
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    // registered product
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign prod = prod_reg;

endmodule

[sv/sspf_shsub.sv]
// Shift-subtract unit shared by the 64-bit divide and the 64-bit square root.
module sspf_shsub
    import sspf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sspf_cmd_t   cmd,
    input  logic [63:0] arg_a,
    input  logic [63:0] arg_b,
    output sspf_stat_t  stat,
    output logic [63:0] result
);

    logic        busy_reg;
    logic        done_reg;
    sspf_op_t    op_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] val_reg;
    logic [63:0] den_reg;
    logic [65:0] rem_reg;
    logic [31:0] root_reg;

    logic [65:0] a_op;
    logic [65:0] b_op;
    logic [66:0] diff;
    logic        ge;
    logic [6:0]  last_cnt;

    // trial subtract: partial remainder against divisor or root trial
    always_comb begin
        if (op_reg == OP_SQRT) begin
            a_op     = {rem_reg[63:0], val_reg[63:62]};
            b_op     = {32'd0, root_reg, 2'b01};
            last_cnt = 7'd31;
        end else begin
            a_op     = {rem_reg[64:0], val_reg[63]};
            b_op     = {2'b00, den_reg};
            last_cnt = 7'd63;
        end
        diff = {1'b0, a_op} - {1'b0, b_op};
        ge   = ~diff[66];
    end

    // one quotient or root bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                op_reg   <= cmd.op;
                val_reg  <= arg_a;
                den_reg  <= arg_b;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (op_reg == OP_SQRT) begin
                    val_reg  <= {val_reg[61:0], 2'b00};
                    root_reg <= {root_reg[30:0], ge};
                end else begin
                    val_reg  <= {val_reg[62:0], ge};
                end
                rem_reg <= ge ? diff[65:0] : a_op;
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == last_cnt) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = (op_reg == OP_SQRT) ? {32'd0, root_reg} : val_reg;

endmodule

[sv/smoothed_split_point_finder.sv]
// Top level of the smoothed split point finder: sequencer and run state.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata  = relationship, seq_number
//  m_        out  m_tvalid/m_tready    m_tdata  = split_relationship, split_seq_number
//  cfg_      in   cfg_valid/cfg_ready  cfg_data = total_count
//
// An item runs from its accept through the 64-step divide and 32-step root on the
// shift-subtract unit; all but the first item of a run add 16 dependent multiplies
// of the decay on the shared multiplier; a run end adds a step for the output load.
// s_tready is high only while the sequencer is idle; cfg_ready is always high.
// A result waits in the output register; a run end stalls while the previous
// result is still waiting there. Synchronous active-low reset; no clearing pass.
`include "assert_macros.svh"

module smoothed_split_point_finder
    import sspf_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] relationship, [47:32] seq_number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] split_relationship, [47:32] split_seq_number
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // [15:0] total_count
);

    localparam int CB = COUNT_BITS;
    localparam int PW = 2 * COUNT_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_P, S_PW, S_NNW, S_DIV, S_SQ0, S_SQRT, S_V0, S_V1, S_V2,
        S_G, S_GW, S_T, S_TW, S_SC0, S_SC1, S_SC2, S_OUT
    } state_t;

    state_t state_reg;

    logic [15:0]   total_count_reg;
    logic [31:0]   prev_value_reg;
    logic [31:0]   prev_smooth_reg;
    logic [CB-1:0] left_count_reg;
    logic [47:0]   best_score_reg;
    logic [31:0]   best_prod_reg;
    logic [31:0]   best_value_reg;
    logic [15:0]   best_seq_reg;

    logic [31:0]   x_reg;
    logic [15:0]   seq_reg;
    logic [CB-1:0] n_reg;
    logic [CB-1:0] left_reg;
    logic [CB-1:0] right_reg;
    logic          first_reg;
    logic          last_reg;
    logic [15:0]   f_reg;
    logic          ip_big_reg;
    logic [5:0]    ip_lo_reg;
    logic [PW-1:0] p_reg;
    logic [63:0]   u_reg;
    logic [31:0]   s_reg;
    logic [63:0]   acc_reg;
    logic [47:0]   v_reg;
    logic [31:0]   g_reg;
    logic [3:0]    gi_reg;
    logic [31:0]   z_reg;

    logic          m_tvalid_reg;
    logic [47:0]   m_tdata_reg;

    // shared units
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    sspf_cmd_t   cmd;
    sspf_stat_t  stat;
    logic [63:0] unit_a;
    logic [63:0] unit_b;
    logic [63:0] unit_res;

    sspf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    sspf_shsub u_shsub (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .arg_a   (unit_a),
        .arg_b   (unit_b),
        .stat    (stat),
        .result  (unit_res)
    );

    // item setup values at accept
    logic [31:0]   tc_ext;
    logic [CB-1:0] n_raw;
    logic [CB-1:0] n_cur;
    logic [CB:0]   k_cur;
    logic          first_cur;
    logic [31:0]   gap;
    logic [34:0]   t_cur;

    always_comb begin
        tc_ext    = 32'(total_count_reg);
        n_raw     = tc_ext[CB-1:0];
        n_cur     = (n_raw == '0) ? CB'(1) : n_raw;
        k_cur     = {1'b0, left_count_reg} + (CB+1)'(1);
        first_cur = (left_count_reg == '0);
        gap       = (s_tdata[31:0] >= prev_value_reg) ? (s_tdata[31:0] - prev_value_reg)
                                                      : 32'd0;
        t_cur     = {3'b000, gap} + {1'b0, gap, 2'b00};
    end

    // decayed term and smoothed score
    logic [5:0]  sh_amt;
    logic [63:0] term;
    logic [32:0] z_sum;
    logic [31:0] z_new;

    always_comb begin
        sh_amt = 6'd31 + ip_lo_reg;
        term   = ip_big_reg ? 64'd0 : (prod >> sh_amt);
        z_sum  = {1'b0, term[31:0]} + {1'b0, ONE_Q16};
        z_new  = z_sum[32] ? 32'hFFFF_FFFF : z_sum[31:0];
    end

    // weighted score and winner test
    logic [79:0] full_prod;
    logic [63:0] sc_wide;
    logic [47:0] sc;
    logic        take;

    always_comb begin
        full_prod = {16'd0, acc_reg} + {prod[47:0], 32'd0};
        sc_wide   = full_prod[79:16];
        sc        = (sc_wide[63:48] != 16'd0) ? SCORE_MAX : sc_wide[47:0];
        take      = first_reg || (sc < best_score_reg) ||
                    ((sc == best_score_reg) && (64'(p_reg) > 64'(best_prod_reg)));
    end

    // multiplier operands and unit commands by step
    always_comb begin
        mul_a  = 32'd0;
        mul_b  = 32'd0;
        cmd    = '{start: 1'b0, op: OP_DIV};
        unit_a = 64'd0;
        unit_b = 64'd0;
        case (state_reg)
            S_P: begin
                mul_a = 32'(left_reg);
                mul_b = 32'(right_reg);
            end
            S_PW: begin
                mul_a = 32'(n_reg);
                mul_b = 32'(n_reg);
            end
            S_NNW: begin
                cmd    = '{start: 1'b1, op: OP_DIV};
                unit_a = {prod[47:0], 16'd0};
                unit_b = 64'(p_reg);
            end
            S_SQ0: begin
                cmd    = '{start: 1'b1, op: OP_SQRT};
                unit_a = {u_reg[47:0], 16'd0};
            end
            S_V0: begin
                mul_a = u_reg[31:0];
                mul_b = s_reg;
            end
            S_V1: begin
                mul_a = u_reg[63:32];
                mul_b = s_reg;
            end
            S_G: begin
                mul_a = g_reg;
                mul_b = K_TAB[gi_reg];
            end
            S_T: begin
                mul_a = prev_smooth_reg;
                mul_b = g_reg;
            end
            S_SC0: begin
                mul_a = v_reg[31:0];
                mul_b = z_reg;
            end
            S_SC1: begin
                mul_a = {16'd0, v_reg[47:32]};
                mul_b = z_reg;
            end
            default: begin
                mul_a = 32'd0;
            end
        endcase
    end

    // sequencer, run state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            total_count_reg <= 16'd1;
            prev_value_reg  <= 32'd0;
            prev_smooth_reg <= ONE_Q16;
            left_count_reg  <= '0;
            best_score_reg  <= 48'd0;
            best_prod_reg   <= 32'd0;
            best_value_reg  <= 32'd0;
            best_seq_reg    <= 16'd0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                total_count_reg <= cfg_data;
            end
            // output drain; the load step handles its own cycle
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x_reg          <= s_tdata[31:0];
                        seq_reg        <= s_tdata[47:32];
                        n_reg          <= n_cur;
                        left_reg       <= first_cur ? CB'(1) : left_count_reg;
                        right_reg      <= (k_cur <= {1'b0, n_cur}) ? (n_cur - left_count_reg)
                                                                   : CB'(1);
                        first_reg      <= first_cur;
                        last_reg       <= (k_cur >= {1'b0, n_cur});
                        f_reg          <= t_cur[15:0];
                        ip_big_reg     <= (t_cur[34:16] > 19'd32);
                        ip_lo_reg      <= t_cur[21:16];
                        prev_value_reg <= s_tdata[31:0];
                        left_count_reg <= k_cur[CB-1:0];
                        state_reg      <= S_P;
                    end
                end
                S_P: begin
                    state_reg <= S_PW;
                end
                S_PW: begin
                    p_reg     <= prod[PW-1:0];
                    state_reg <= S_NNW;
                end
                S_NNW: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (stat.done) begin
                        u_reg     <= unit_res;
                        state_reg <= S_SQ0;
                    end
                end
                S_SQ0: begin
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    if (stat.done) begin
                        s_reg     <= unit_res[31:0];
                        state_reg <= S_V0;
                    end
                end
                S_V0: begin
                    state_reg <= S_V1;
                end
                S_V1: begin
                    acc_reg   <= prod;
                    state_reg <= S_V2;
                end
                S_V2: begin
                    v_reg  <= 48'((acc_reg + {prod[31:0], 32'd0}) >> 16);
                    g_reg  <= 32'h8000_0000;
                    gi_reg <= 4'd0;
                    if (first_reg) begin
                        z_reg     <= ONE_Q16;
                        state_reg <= S_SC0;
                    end else begin
                        state_reg <= S_G;
                    end
                end
                S_G: begin
                    state_reg <= S_GW;
                end
                S_GW: begin
                    // bit 15-i of the fraction is the bitwise inverse of i
                    if (f_reg[~gi_reg]) begin
                        g_reg <= prod[63:32];
                    end
                    gi_reg    <= gi_reg + 4'd1;
                    state_reg <= (gi_reg == 4'd15) ? S_T : S_G;
                end
                S_T: begin
                    state_reg <= S_TW;
                end
                S_TW: begin
                    z_reg     <= z_new;
                    state_reg <= S_SC0;
                end
                S_SC0: begin
                    state_reg <= S_SC1;
                end
                S_SC1: begin
                    acc_reg   <= prod;
                    state_reg <= S_SC2;
                end
                S_SC2: begin
                    if (take) begin
                        best_score_reg <= sc;
                        best_prod_reg  <= 32'(p_reg);
                        best_value_reg <= x_reg;
                        best_seq_reg   <= seq_reg;
                    end
                    prev_smooth_reg <= z_reg;
                    state_reg       <= last_reg ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg     <= {best_seq_reg, best_value_reg};
                        m_tvalid_reg    <= 1'b1;
                        prev_value_reg  <= 32'd0;
                        prev_smooth_reg <= ONE_Q16;
                        left_count_reg  <= '0;
                        best_score_reg  <= 48'd0;
                        best_prod_reg   <= 32'd0;
                        best_value_reg  <= 32'd0;
                        best_seq_reg    <= 16'd0;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // checks on sequencing
    `SSPF_ASSERT_NXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SSPF_ASSERT_IMP(a_start_idle, aclk, aresetn, cmd.start, !stat.busy)
    `SSPF_ASSERT_IMP(a_ready_unit, aclk, aresetn, s_tready, !stat.busy)
    `SSPF_ASSERT_IMP(a_out_src, aclk, aresetn, $rose(m_tvalid), $past(state_reg == S_OUT))

endmodule

[tb/sv/tb_smoothed_split_point_finder.sv]
// Self-checking testbench of the smoothed split point finder.
`timescale 1ns / 1ps

module tb_smoothed_split_point_finder;

    typedef struct {
        logic [31:0] rel;
        logic [15:0] seq;
    } rel_item_t;

    typedef struct {
        logic [31:0] rel;
        logic [15:0] seq;
    } split_t;

    localparam int COUNT_BITS   = 16;
    localparam int WATCHDOG_MAX = 20000;
    localparam int SETTLE_CYC   = 300;
    localparam int HOLD_CYC     = 2500;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [31:0] relationship, [47:32] seq_number
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [31:0] split_relationship, [47:32] split_seq_number
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;  // [15:0] total_count

    smoothed_split_point_finder #(.COUNT_BITS(COUNT_BITS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    rel_item_t pending_items[$];
    split_t    expected_splits[$];
    int        mismatches;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_req;
    int        hold_seen;
    int        hold_left;
    int        quiet_cycles;

    // predictor state
    logic [15:0] run_len;
    logic [31:0] last_rel;
    logic [31:0] last_smooth;
    logic [15:0] seen_cnt;
    logic [63:0] win_score;
    logic [31:0] win_prod;
    logic [31:0] win_rel;
    logic [15:0] win_seq;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > val) b = b >> 2;
        while (b != 0) begin
            if (val >= r + b) begin
                val = val - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // z = pz * 32^-gap + 1, Q16.16
    function automatic logic [31:0] decay_smooth(input logic [31:0] pz, input logic [31:0] gap);
        logic [63:0] t;
        logic [63:0] ip;
        logic [15:0] f;
        logic [63:0] g;
        logic [63:0] k;
        logic [63:0] term;
        logic [63:0] z;
        t  = 64'd5 * {32'd0, gap};
        ip = t >> 16;
        f  = t[15:0];
        g  = 64'd1 << 31;
        k  = floor_sqrt(64'd1 << 63);
        for (int i = 1; i <= 16; i++) begin
            if (f[16 - i]) g = (g * k) >> 32;
            k = floor_sqrt(k << 32);
        end
        term = (ip > 32) ? 64'd0 : (({32'd0, pz} * g) >> (31 + ip));
        z    = term + 64'h10000;
        return (z > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : z[31:0];
    endfunction

    // n^3 / p^1.5 times z, saturated to 48 bits
    function automatic logic [63:0] weighted_score(input logic [31:0] z, input logic [63:0] n,
                                                   input logic [63:0] p);
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] sc;
        u  = ((n * n) << 16) / p;
        s  = floor_sqrt(u << 16);
        v  = (u * s) >> 16;
        sc = v * {48'd0, z[31:16]} + ((v * {48'd0, z[15:0]}) >> 16);
        return (sc > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : sc;
    endfunction

    task automatic clear_run();
        last_rel    = 32'd0;
        last_smooth = 32'h10000;
        seen_cnt    = 16'd0;
        win_score   = 64'd0;
        win_prod    = 32'd0;
        win_rel     = 32'd0;
        win_seq     = 16'd0;
    endtask

    // advance the predictor by one accepted item
    task automatic predict_split(input logic [31:0] x, input logic [15:0] sq);
        logic [63:0] n;
        logic [63:0] k;
        logic [63:0] lft;
        logic [63:0] rgt;
        logic [63:0] p;
        logic [63:0] sc;
        logic [31:0] z;
        logic        first;
        split_t      res;
        n     = (run_len == 16'd0) ? 64'd1 : {48'd0, run_len};
        k     = {48'd0, seen_cnt} + 64'd1;
        first = (k == 64'd1);
        if (first) z = 32'h10000;
        else z = decay_smooth(last_smooth, (x >= last_rel) ? x - last_rel : 32'd0);
        lft = first ? 64'd1 : k - 64'd1;
        rgt = (k <= n) ? n - k + 64'd1 : 64'd1;
        p   = lft * rgt;
        sc  = weighted_score(z, n, p);
        if (first || sc < win_score || (sc == win_score && p > {32'd0, win_prod})) begin
            win_score = sc;
            win_prod  = p[31:0];
            win_rel   = x;
            win_seq   = sq;
        end
        last_rel    = x;
        last_smooth = z;
        seen_cnt    = k[15:0];
        if (k >= n) begin
            res.rel = win_rel;
            res.seq = win_seq;
            expected_splits.push_back(res);
            clear_run();
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 48'd0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= {pending_items[0].seq, pending_items[0].rel};
                s_tvalid <= 1'b1;
                void'(pending_items.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYC;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge aclk) begin
        split_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) run_len = cfg_data;
            if (s_tvalid && s_tready) predict_split(s_tdata[31:0], s_tdata[47:32]);
            if (m_tvalid && m_tready) begin
                if (expected_splits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected split: rel %h seq %h", m_tdata[31:0], m_tdata[47:32]);
                end else begin
                    want = expected_splits.pop_front();
                    if (want.rel !== m_tdata[31:0] || want.seq !== m_tdata[47:32]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("split mismatch: exp rel %h seq %h, got rel %h seq %h",
                                     want.rel, want.seq, m_tdata[31:0], m_tdata[47:32]);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [31:0] x, input logic [15:0] sq);
        rel_item_t it;
        it.rel = x;
        it.seq = sq;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_splits.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_len(input logic [15:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one ascending run with random content; a few items step backwards
    task automatic push_run(input int cnt);
        logic [31:0] x;
        logic [63:0] nx;
        int          kind;
        kind = $urandom_range(3);
        x    = (kind == 3) ? $urandom() : $urandom_range(32'h0010_0000);
        for (int i = 0; i < cnt; i++) begin
            push_item(x, 16'($urandom_range(16'hFFFF)));
            if ($urandom_range(9) == 0) begin
                x = $urandom();
            end else begin
                case ($urandom_range(3))
                    0: nx = {32'd0, x} + 64'($urandom_range(16'h0FFF));
                    1: nx = {32'd0, x} + 64'($urandom_range(32'h0003_0000));
                    2: nx = {32'd0, x} + 64'($urandom_range(32'h000A_0000));
                    default: nx = {32'd0, x} + 64'($urandom());
                endcase
                x = (nx > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nx[31:0];
            end
        end
    endtask

    initial begin
        int sent;
        int n;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 16'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        mismatches     = 0;
        run_len        = 16'd1;
        clear_run();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes with the reset run length
        push_item(32'h0000_0000, 16'h0000);
        push_item(32'hFFFF_FFFF, 16'hFFFF);
        // zero run length acts as one
        write_len(16'd0);
        push_item(32'h1234_5678, 16'hA5A5);
        push_item(32'h0000_0001, 16'h5A5A);
        // small gaps, a descending value, then a huge gap
        write_len(16'd3);
        push_item(32'h0001_0000, 16'd1);
        push_item(32'h0001_0001, 16'd2);
        push_item(32'h0001_8000, 16'd3);
        push_item(32'h0005_0000, 16'd4);
        push_item(32'h0002_0000, 16'd5);
        push_item(32'h0002_4000, 16'd6);
        push_item(32'h0000_0000, 16'd7);
        push_item(32'h0010_0000, 16'd8);
        push_item(32'hFFFF_0000, 16'd9);
        // longest run length, then lowered mid run
        write_len(16'hFFFF);
        push_item(32'h0000_1000, 16'd10);
        push_item(32'h0000_2000, 16'd11);
        push_item(32'h0000_3000, 16'd12);
        write_len(16'd2);
        push_item(32'h0000_4000, 16'd13);
        push_item(32'h0000_5000, 16'd14);
        push_item(32'h0000_6000, 16'd15);

        // random phases: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            send_idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 18 : 0;
            recv_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 18 : 0;
            sent = 0;
            if (ph == 0) begin
                // receiver holds off while runs of one keep arriving
                write_len(16'd1);
                push_run(30);
                hold_req = hold_req + 1;
                sent = 30;
            end
            while (sent < 170) begin
                case ($urandom_range(9))
                    0: n = 1;
                    1: n = 2;
                    2: n = $urandom_range(24, 40);
                    default: n = $urandom_range(3, 12);
                endcase
                write_len(n[15:0]);
                push_run(n);
                sent = sent + n;
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
